@@ sv/bsl_pkg.sv @@
// ----------------------------------------------------------------------------
// Reply deframer package
// Shared types and constants for the bootstrap-loader reply deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsl_pkg;

    // Frame type bytes and frame framing constants.
    localparam logic [7:0] HDR_BYTE       = 8'h80;
    localparam logic [7:0] ACK_BYTE       = 8'h90;
    localparam logic [7:0] NAK_BYTE       = 8'hA0;
    localparam logic [7:0] XOR_SEED       = 8'hff;
    localparam logic [8:0] FRAME_OVERHEAD = 9'd6;

    // Frame buffer size; a data frame that reaches it without completing overflows.
    localparam logic [8:0] BUFFER_BYTES   = 9'd256;

    // Widths of the packed stream payloads.
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 40;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ACK      = 3'd0,
        ST_OK       = 3'd1,
        ST_BADSUM   = 3'd2,
        ST_NAK      = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_TIMEOUT  = 3'd5,
        ST_OVERFLOW = 3'd6
    } t_status;

    // Running state of the frame being received.
    typedef struct packed {
        logic [8:0] byte_count;
        logic [7:0] length_byte;
        logic [7:0] xor_even;
        logic [7:0] xor_odd;
    } t_frame_state;

    // One result item.
    typedef struct packed {
        logic [7:0] residue_odd;
        logic [7:0] residue_even;
        logic [7:0] declared_length;
        logic [8:0] frame_bytes;
        t_status    status;
    } t_result;

    localparam t_frame_state FRAME_CLEAR = '{
        byte_count:  9'd0,
        length_byte: 8'd0,
        xor_even:    XOR_SEED,
        xor_odd:     XOR_SEED
    };

endpackage

`default_nettype wire

@@ sv/bsl_frame_eval.sv @@
// ----------------------------------------------------------------------------
// Reply frame evaluator
// Judges one received byte or timeout against the running frame state and
// produces the next state and, when the frame ends, its result.
// ----------------------------------------------------------------------------
`default_nettype none

module bsl_frame_eval
    import bsl_pkg::*;
(
    input  var t_frame_state i_state,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_timeout,
    output t_frame_state     o_next_state,
    output logic             o_res_valid,
    output t_result          o_result
);

    logic [8:0] pos;
    logic [8:0] cnt;
    logic [7:0] xe_upd;
    logic [7:0] xo_upd;
    logic [7:0] len_upd;
    logic [9:0] target;
    logic       done;
    logic       sum_ok;

    // Running sums, count and captured length after this byte.
    always_comb begin
        pos     = i_state.byte_count;
        cnt     = pos + 9'd1;
        xe_upd  = pos[0] ? i_state.xor_even : (i_state.xor_even ^ i_rx_byte);
        xo_upd  = pos[0] ? (i_state.xor_odd ^ i_rx_byte) : i_state.xor_odd;
        len_upd = (pos == 9'd2) ? i_rx_byte : i_state.length_byte;
        target  = {2'b00, len_upd} + {1'b0, FRAME_OVERHEAD};
        done    = (cnt >= FRAME_OVERHEAD) && ({1'b0, cnt} == target);
        sum_ok  = (xe_upd == 8'd0) && (xo_upd == 8'd0);
    end

    // Frame decision.
    always_comb begin
        o_res_valid  = 1'b0;
        o_next_state = '{byte_count: cnt, length_byte: len_upd,
                         xor_even: xe_upd, xor_odd: xo_upd};
        o_result     = '{residue_odd: xo_upd, residue_even: xe_upd,
                         declared_length: len_upd, frame_bytes: cnt,
                         status: ST_OVERFLOW};
        if (i_timeout) begin
            o_res_valid  = 1'b1;
            o_next_state = FRAME_CLEAR;
            o_result     = '{residue_odd: i_state.xor_odd,
                             residue_even: i_state.xor_even,
                             declared_length: i_state.length_byte,
                             frame_bytes: i_state.byte_count,
                             status: ST_TIMEOUT};
        end else if ((pos == 9'd0) && (i_rx_byte != HDR_BYTE)) begin
            // Single-byte frames report only their type.
            o_res_valid  = 1'b1;
            o_next_state = FRAME_CLEAR;
            o_result     = '{residue_odd: 8'd0, residue_even: 8'd0,
                             declared_length: 8'd0, frame_bytes: 9'd1,
                             status: ST_UNKNOWN};
            if (i_rx_byte == ACK_BYTE) begin
                o_result.status = ST_ACK;
            end else if (i_rx_byte == NAK_BYTE) begin
                o_result.status = ST_NAK;
            end
        end else if (done) begin
            o_res_valid     = 1'b1;
            o_next_state    = FRAME_CLEAR;
            o_result.status = sum_ok ? ST_OK : ST_BADSUM;
        end else if (cnt >= BUFFER_BYTES) begin
            o_res_valid     = 1'b1;
            o_next_state    = FRAME_CLEAR;
            o_result.status = ST_OVERFLOW;
        end
    end

endmodule

`default_nettype wire

@@ sv/bsl_out_slice.sv @@
// ----------------------------------------------------------------------------
// Result output slice
// Two-entry skid register between the evaluator and the result stream, so
// that its upstream ready is a register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsl_out_slice
    import bsl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  var t_result i_result,
    output logic      o_ready,
    output logic      o_valid,
    output t_result   o_result,
    input  wire logic i_take
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop      = r_main_valid && i_take;
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

    // Control: main holds the shown result, skid catches one more.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (!r_main_valid || pop) begin
                    r_main_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                r_main_valid <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/bsl_reply_deframer.sv @@
// ----------------------------------------------------------------------------
// Bootstrap-loader reply deframer
// Recognizes one reply frame at a time from received bytes and timeouts.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata: rx_byte[7:0]; tuser: timeout
//  m_axis    out        tdata: status, frame_bytes, declared_length,
//                              residue_even, residue_odd (zero padded)
//
//  One item is accepted per cycle while input ready is high; each passes an
//  input register, the frame evaluator and a two-entry output skid register.
//  Bytes that end no frame produce no result.
//  Synchronous active-low reset clears the frame state and all valid flags.
//  A stalled result stream fills the skid register, then input ready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module bsl_reply_deframer
    import bsl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  wire logic                  i_s_axis_tuser,   // [0] timeout
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [2:0] status, [11:3] frame_bytes, [19:12] declared_length,
    // [27:20] residue_even, [35:28] residue_odd, [39:36] zero
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_timeout;
    t_frame_state r_state;
    t_frame_state n_state;
    logic         res_valid;
    t_result      res;
    logic         slice_ready;
    logic         advance;
    logic         push;
    t_result      out_res;

    assign advance         = r_in_valid && (!res_valid || slice_ready);
    assign push            = r_in_valid && res_valid && slice_ready;
    assign o_s_axis_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte    <= i_s_axis_tdata;
            r_in_timeout <= i_s_axis_tuser;
        end
    end

    // Frame state advances as each item leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FRAME_CLEAR;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    bsl_frame_eval u_eval (
        .i_state      (r_state),
        .i_rx_byte    (r_in_byte),
        .i_timeout    (r_in_timeout),
        .o_next_state (n_state),
        .o_res_valid  (res_valid),
        .o_result     (res)
    );

    bsl_out_slice u_slice (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (res),
        .o_ready  (slice_ready),
        .o_valid  (o_m_axis_tvalid),
        .o_result (out_res),
        .i_take   (i_m_axis_tready)
    );

    // Result packing, first field lowest.
    assign o_m_axis_tdata = {4'b0000, out_res.residue_odd, out_res.residue_even,
                             out_res.declared_length, out_res.frame_bytes,
                             out_res.status};

endmodule

`default_nettype wire

@@ sv/bsl_reply_deframer_chk.sv @@
// ----------------------------------------------------------------------------
// Reply deframer port checker
// Checks on the result stream of the reply deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsl_reply_deframer_chk
    import bsl_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // No result survives reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Status is always a defined code.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[2:0] != 3'd7)
        else $error("undefined status code");

    // Single-byte frames carry one byte and no sums.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[2:0] == ST_ACK
            || o_m_axis_tdata[2:0] == ST_NAK || o_m_axis_tdata[2:0] == ST_UNKNOWN)
        |-> o_m_axis_tdata[11:3] == 9'd1 && o_m_axis_tdata[35:12] == 24'd0)
        else $error("single-byte frame fields wrong");

    // Frame length never passes the buffer.
    a_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[11:3] <= BUFFER_BYTES)
        else $error("frame byte count beyond buffer");

endmodule

bind bsl_reply_deframer bsl_reply_deframer_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
